FILE: design/eia_pkg.sv
`timescale 1ns / 1ps
package eia_pkg;

  localparam int unsigned DefWidth = 32;
  localparam int unsigned QDepth   = 2;

  typedef enum logic [4:0] {
    CMD_ADD = 5'd0,
    CMD_SUB = 5'd1,
    CMD_MUL = 5'd2,
    CMD_DIV = 5'd3,
    CMD_MOD = 5'd4,
    CMD_POW = 5'd5,
    CMD_MIN = 5'd6,
    CMD_MAX = 5'd7,
    CMD_AND = 5'd8,
    CMD_OR  = 5'd9,
    CMD_XOR = 5'd10,
    CMD_EQ  = 5'd11,
    CMD_NE  = 5'd12,
    CMD_LT  = 5'd13,
    CMD_LE  = 5'd14,
    CMD_GT  = 5'd15,
    CMD_GE  = 5'd16
  } cmd_e;

  typedef enum logic [1:0] {
    UNIT_ALU = 2'd0,
    UNIT_DIV = 2'd1,
    UNIT_POW = 2'd2
  } unit_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_DFIN = 4'b0100,
    ST_POW  = 4'b1000
  } state_e;

  typedef struct packed {
    logic [4:0]  cmd;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic [31:0] result;
    logic        divide_by_zero;
  } out_t;

  typedef struct packed {
    in_t   item;
    unit_e unit;
    logic  sgn;
    logic  a_neg;
    logic  b_neg;
  } entry_t;

endpackage

FILE: design/eia_front.sv
`timescale 1ns / 1ps
module eia_front import eia_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   cfg_we_i,
  input  logic   cfg_wdata_i,
  input  in_t    item_i,
  output entry_t entry_o
);

  logic             sgn_q;
  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sgn_q <= 1'b1;
    end else if (cfg_we_i) begin
      sgn_q <= cfg_wdata_i;
    end
  end

  assign a = WIDTH'(item_i.operand_a);
  assign b = WIDTH'(item_i.operand_b);

  always_comb begin
    entry_o.item  = item_i;
    entry_o.sgn   = sgn_q;
    entry_o.a_neg = sgn_q & a[WIDTH-1];
    entry_o.b_neg = sgn_q & b[WIDTH-1];
    entry_o.unit  = UNIT_ALU;
    if ((item_i.cmd == CMD_DIV || item_i.cmd == CMD_MOD) && b != '0) begin
      entry_o.unit = UNIT_DIV;
    end else if (item_i.cmd == CMD_POW && !(sgn_q & b[WIDTH-1])) begin
      entry_o.unit = UNIT_POW;
    end
  end

endmodule

FILE: design/eia_queue.sv
`timescale 1ns / 1ps
module eia_queue import eia_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   head_valid_o,
  output logic   full_o,
  output logic [$clog2(QDepth+1)-1:0] cnt_o
);

  localparam int unsigned PW = $clog2(QDepth);
  localparam int unsigned CW = $clog2(QDepth + 1);

  entry_t          mem_q [QDepth];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [CW-1:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(QDepth - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(QDepth - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  assign head_o       = mem_q[rptr_q];
  assign head_valid_o = cnt_q != '0;
  assign full_o       = cnt_q == CW'(QDepth);
  assign cnt_o        = cnt_q;

endmodule

FILE: design/eia_back.sv
`timescale 1ns / 1ps
module eia_back import eia_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  entry_t head_i,
  input  logic   head_valid_i,
  output logic   pop_o,
  output logic   valid_o,
  output out_t   out_o
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  state_e           state_q, state_d;
  logic             valid_q, valid_d;
  out_t             out_q, out_d;
  logic [WIDTH-1:0] quo_q, quo_d, rem_q, rem_d, mb_q, mb_d, b_q, b_d;
  logic [WIDTH-1:0] acc_q, acc_d, base_q, base_d, exp_q, exp_d;
  logic             na_q, na_d, nb_q, nb_d, mod_q, mod_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  logic [WIDTH-1:0] a, b, sbit, alu_res, ma, mb, qf, rt, mres;
  logic             alu_dz, a_lt_b, b_lt_a;
  logic [WIDTH:0]   rem_sh, diff;

  assign a      = WIDTH'(head_i.item.operand_a);
  assign b      = WIDTH'(head_i.item.operand_b);
  assign sbit   = {head_i.sgn, {(WIDTH-1){1'b0}}};
  assign a_lt_b = (a ^ sbit) < (b ^ sbit);
  assign b_lt_a = (b ^ sbit) < (a ^ sbit);
  assign ma     = head_i.a_neg ? -a : a;
  assign mb     = head_i.b_neg ? -b : b;

  always_comb begin
    alu_res = '0;
    alu_dz  = 1'b0;
    case (head_i.item.cmd)
      CMD_ADD: alu_res = a + b;
      CMD_SUB: alu_res = a - b;
      CMD_MUL: alu_res = WIDTH'(a * b);
      CMD_DIV: begin
        alu_dz = 1'b1;
      end
      CMD_MOD: begin
        alu_res = a;
        alu_dz  = 1'b1;
      end
      CMD_POW: begin
        if (a == WIDTH'(1)) begin
          alu_res = WIDTH'(1);
        end else if (head_i.sgn && a == '1) begin
          alu_res = b[0] ? '1 : WIDTH'(1);
        end
      end
      CMD_MIN: alu_res = b_lt_a ? b : a;
      CMD_MAX: alu_res = a_lt_b ? b : a;
      CMD_AND: alu_res = a & b;
      CMD_OR:  alu_res = a | b;
      CMD_XOR: alu_res = a ^ b;
      CMD_EQ:  alu_res = WIDTH'(a == b);
      CMD_NE:  alu_res = WIDTH'(a != b);
      CMD_LT:  alu_res = WIDTH'(a_lt_b);
      CMD_LE:  alu_res = WIDTH'(!b_lt_a);
      CMD_GT:  alu_res = WIDTH'(b_lt_a);
      CMD_GE:  alu_res = WIDTH'(!a_lt_b);
      default: alu_res = '0;
    endcase
  end

  assign rem_sh = {rem_q, quo_q[WIDTH-1]};
  assign diff   = rem_sh - {1'b0, mb_q};
  assign qf     = (na_q != nb_q) ? ((rem_q != '0) ? ~quo_q : -quo_q) : quo_q;
  assign rt     = na_q ? -rem_q : rem_q;
  assign mres   = (rem_q != '0 && na_q != nb_q) ? rt + b_q : rt;

  always_comb begin
    state_d = state_q;
    valid_d = 1'b0;
    out_d   = out_q;
    pop_o   = 1'b0;
    quo_d   = quo_q;
    rem_d   = rem_q;
    mb_d    = mb_q;
    b_d     = b_q;
    na_d    = na_q;
    nb_d    = nb_q;
    mod_d   = mod_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    base_d  = base_q;
    exp_d   = exp_q;
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          case (head_i.unit)
            UNIT_DIV: begin
              quo_d   = ma;
              rem_d   = '0;
              mb_d    = mb;
              b_d     = b;
              na_d    = head_i.a_neg;
              nb_d    = head_i.b_neg;
              mod_d   = head_i.item.cmd == CMD_MOD;
              cnt_d   = '0;
              state_d = ST_DIV;
            end
            UNIT_POW: begin
              acc_d   = WIDTH'(1);
              base_d  = a;
              exp_d   = b;
              state_d = ST_POW;
            end
            default: begin
              valid_d              = 1'b1;
              out_d.result         = 32'(alu_res);
              out_d.divide_by_zero = alu_dz;
            end
          endcase
        end
      end
      ST_DIV: begin
        rem_d = diff[WIDTH] ? rem_sh[WIDTH-1:0] : diff[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], ~diff[WIDTH]};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(WIDTH - 1)) begin
          state_d = ST_DFIN;
        end
      end
      ST_DFIN: begin
        valid_d              = 1'b1;
        out_d.result         = 32'(mod_q ? mres : qf);
        out_d.divide_by_zero = 1'b0;
        state_d              = ST_IDLE;
      end
      ST_POW: begin
        if (exp_q == '0) begin
          valid_d              = 1'b1;
          out_d.result         = 32'(acc_q);
          out_d.divide_by_zero = 1'b0;
          state_d              = ST_IDLE;
        end else begin
          acc_d  = exp_q[0] ? WIDTH'(acc_q * base_q) : acc_q;
          base_d = WIDTH'(base_q * base_q);
          exp_d  = exp_q >> 1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    mb_q   <= mb_d;
    b_q    <= b_d;
    na_q   <= na_d;
    nb_q   <= nb_d;
    mod_q  <= mod_d;
    cnt_q  <= cnt_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    exp_q  <= exp_d;
  end

  assign valid_o = valid_q;
  assign out_o   = out_q;

endmodule

FILE: design/elementwise_integer_alu.sv
`timescale 1ns / 1ps
// Channel   Ports                          Transfer
// input     start_i, busy_o, in_i          start_i high and busy_o low
// result    out_valid_o, out_o             one-cycle strobe, always taken
// config    cfg_we_i, cfg_wdata_i          cfg_we_i high
//
// Simple ops and multiply: one item per cycle while no divide or pow is running.
// floordiv/mod with nonzero divisor: computed by the 1-bit/cycle divider.
// pow with nonnegative exponent: one exponent bit per cycle.
// busy_o rises while the two-entry queue is full behind a long operation.
// Reset sets signed mode and empties the queue.
module elementwise_integer_alu import eia_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  in_t  in_i,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  output logic out_valid_o,
  output out_t out_o
);

  entry_t                       entry, head;
  logic                         push, pop, head_valid, full;
  logic [$clog2(QDepth+1)-1:0]  q_cnt;

  assign push   = start_i & ~full;
  assign busy_o = full;

  eia_front #(.WIDTH(WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (in_i),
    .entry_o    (entry)
  );

  eia_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .entry_i     (entry),
    .pop_i       (pop),
    .head_o      (head),
    .head_valid_o(head_valid),
    .full_o      (full),
    .cnt_o       (q_cnt)
  );

  eia_back #(.WIDTH(WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .head_valid_i(head_valid),
    .pop_o       (pop),
    .valid_o     (out_valid_o),
    .out_o       (out_o)
  );

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> q_cnt != '0)
    else $error("accepted item missing from queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_cnt != '0)
    else $error("pop from empty queue");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import eia_pkg::*;

  localparam int unsigned W = DefWidth;
  localparam logic [W-1:0] MASK = '1;
  localparam logic [W-1:0] SIGN = {1'b1, {(W-1){1'b0}}};

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  in_t  in_i;
  logic cfg_we_i;
  logic cfg_wdata_i;
  logic out_valid_o;
  out_t out_o;

  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned results_seen;
  logic        signed_mode_q;

  elementwise_integer_alu dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .out_valid_o(out_valid_o),
    .out_o      (out_o)
  );

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic is_neg(logic sm, logic [W-1:0] v);
    return sm && v[W-1];
  endfunction

  function automatic logic lt(logic sm, logic [W-1:0] a, logic [W-1:0] b);
    if (sm) begin
      a ^= SIGN;
      b ^= SIGN;
    end
    return a < b;
  endfunction

  function automatic logic [W-1:0] floor_quot(logic sm, logic [W-1:0] a,
                                              logic [W-1:0] b);
    logic na, nb;
    logic [W-1:0] ma, mb, q, r;
    na = is_neg(sm, a);
    nb = is_neg(sm, b);
    ma = na ? -a : a;
    mb = nb ? -b : b;
    q = ma / mb;
    r = ma % mb;
    if (na != nb) begin
      q = -q;
      if (r != 0) q = q - 1;
    end
    return q;
  endfunction

  function automatic logic [W-1:0] int_pow(logic sm, logic [W-1:0] a,
                                           logic [W-1:0] b);
    logic [W-1:0] acc, base;
    acc = 1;
    base = a;
    if (is_neg(sm, b)) begin
      if (a == 1) return 1;
      if (a == MASK) return b[0] ? MASK : 1;
      return 0;
    end
    for (int i = 0; i < W; i++) begin
      if (b[i]) acc = acc * base;
      base = base * base;
    end
    return acc;
  endfunction

  function automatic out_t alu_predict(logic sm, in_t it);
    out_t o;
    logic [W-1:0] a, b, r;
    a = it.operand_a;
    b = it.operand_b;
    r = '0;
    o.divide_by_zero = 1'b0;
    case (it.cmd)
      CMD_ADD: r = a + b;
      CMD_SUB: r = a - b;
      CMD_MUL: r = a * b;
      CMD_DIV: begin
        if (b == 0) o.divide_by_zero = 1'b1;
        else r = floor_quot(sm, a, b);
      end
      CMD_MOD: begin
        if (b == 0) begin
          r = a;
          o.divide_by_zero = 1'b1;
        end else begin
          r = a - floor_quot(sm, a, b) * b;
        end
      end
      CMD_POW: r = int_pow(sm, a, b);
      CMD_MIN: r = lt(sm, b, a) ? b : a;
      CMD_MAX: r = lt(sm, a, b) ? b : a;
      CMD_AND: r = a & b;
      CMD_OR:  r = a | b;
      CMD_XOR: r = a ^ b;
      CMD_EQ:  r = W'(a == b);
      CMD_NE:  r = W'(a != b);
      CMD_LT:  r = W'(lt(sm, a, b));
      CMD_LE:  r = W'(!lt(sm, b, a));
      CMD_GT:  r = W'(lt(sm, b, a));
      CMD_GE:  r = W'(!lt(sm, a, b));
      default: r = '0;
    endcase
    o.result = r;
    return o;
  endfunction

  class alu_scoreboard;
    out_t pending_q[$];

    function void note_item(logic sm, in_t it);
      pending_q = {pending_q, alu_predict(sm, it)};
    endfunction

    task check_result(out_t got);
      out_t exp_o;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      exp_o = pending_q.pop_front();
      if (got.result !== exp_o.result)
        report_mismatch($sformatf("result %h, want %h", got.result, exp_o.result));
      if (got.divide_by_zero !== exp_o.divide_by_zero)
        report_mismatch($sformatf("divide_by_zero %b, want %b",
                                  got.divide_by_zero, exp_o.divide_by_zero));
    endtask
  endclass

  alu_scoreboard sb = new();

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      sb.check_result(out_o);
      results_seen++;
    end
  end

  task automatic send_item(input in_t it, input int unsigned gap);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_item(signed_mode_q, it);
    items_sent++;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (W + 8) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    signed_mode_q = v;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return 32'h8000_0000;
      4: return 32'h7fff_ffff;
      5: return $urandom_range(0, 15);
      6: return -$urandom_range(1, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int n, input logic bursty);
    in_t it;
    for (int i = 0; i < n; i++) begin
      it.cmd = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31))
                                            : 5'($urandom_range(0, 16));
      it.operand_a = pick_operand();
      it.operand_b = pick_operand();
      send_item(it, bursty ? 0 : $urandom_range(0, 6));
    end
  endtask

  initial begin
    in_t it;
    logic [31:0] edge_a[6] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000,
                               32'h7fff_ffff, 32'h5};
    mismatch_count = 0;
    items_sent = 0;
    results_seen = 0;
    signed_mode_q = 1'b1;
    rst_ni = 1'b0;
    start_i = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int c = 0; c <= CMD_GE; c++) begin
      it.cmd = 5'(c);
      it.operand_a = edge_a[c % 6];
      it.operand_b = edge_a[(c + 3) % 6];
      send_item(it, 0);
    end
    it = '{cmd: CMD_DIV, operand_a: 32'h8000_0000, operand_b: '1};
    send_item(it, 0);
    it.cmd = CMD_MOD;
    send_item(it, 1);
    it = '{cmd: CMD_DIV, operand_a: 32'd7, operand_b: 32'd0};
    send_item(it, 0);
    it.cmd = CMD_MOD;
    send_item(it, 0);
    it = '{cmd: CMD_POW, operand_a: '1, operand_b: 32'hffff_fffd};
    send_item(it, 0);
    it.operand_a = 32'd0;
    it.operand_b = 32'd0;
    send_item(it, 2);
    it = '{cmd: 5'd31, operand_a: '1, operand_b: '1};
    send_item(it, 0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph[0]);
      send_random(150, 1'b0);
      send_random(60, 1'b1);
      drain();
      send_random(100, 1'b0);
      drain();
    end
    write_mode(1'b1);
    send_random(60, 1'b0);
    drain();

    $display("Ran %0d items over all 17 ops, both signedness modes, with %0d results.",
             items_sent, results_seen);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
design/eia_pkg.sv
design/eia_front.sv
design/eia_queue.sv
design/eia_back.sv
design/elementwise_integer_alu.sv
verif/testbench.sv
